@@ rtl/lidar_packet_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the lidar packet deframer
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LIDAR_PACKET_DEFRAMER_DEFINES_SVH
`define LIDAR_PACKET_DEFRAMER_DEFINES_SVH

// Check a property on every rising clock edge out of reset
`define LPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition implies another one on the next edge
`define LPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/ldpd_pkg.sv @@
// ---------------------------------------------------------------------------
// ldpd_pkg
// Constants and the reading record shared by the deframer modules.
// ---------------------------------------------------------------------------
package ldpd_pkg;

  // Packet framing
  localparam logic [7:0] SYNC_BYTE     = 8'hFA;
  localparam logic [7:0] SECTOR_LOW    = 8'hA0;
  localparam logic [7:0] SECTOR_HIGH   = 8'hDB;
  localparam logic [5:0] PACKET_BYTES  = 6'd42;
  localparam logic [5:0] POS_SECTOR    = 6'd1;
  localparam logic [5:0] POS_SPEED_LO  = 6'd2;
  localparam logic [5:0] POS_SPEED_HI  = 6'd3;
  localparam logic [5:0] FIRST_READING = 6'd4;
  localparam logic [5:0] READINGS_END  = 6'd40;
  localparam logic [2:0] LAST_READING  = 3'd5;

  // Angle: (269 + 360 - index) folded into 0..359
  localparam logic [9:0] ANGLE_START   = 10'd629;
  localparam logic [9:0] FULL_TURN     = 10'd360;

  // Speed / 10 as (speed * 52429) >> 19, exact for 16-bit speeds
  localparam logic [15:0] RPM_RECIP    = 16'd52429;
  localparam int          RPM_SHIFT    = 19;

  // One reading as handed from the parser to the output stage
  typedef struct packed {
    logic [8:0]  angle_idx;
    logic [15:0] range_mm;
    logic [15:0] intensity;
    logic [15:0] speed_word;
    logic        last;
  } reading_t;

endpackage

@@ rtl/ldpd_front.sv @@
// ---------------------------------------------------------------------------
// ldpd_front
// Byte parser: hunts for sync, tracks the packet position and emits one
// reading record per range high byte of a valid packet.
// ---------------------------------------------------------------------------
module ldpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output logic              rec_valid_o,
  output ldpd_pkg::reading_t rec_o
);

  // Byte offsets within one 6-byte reading
  localparam logic [2:0] OFF_INT_LO   = 3'd0;
  localparam logic [2:0] OFF_INT_HI   = 3'd1;
  localparam logic [2:0] OFF_RANGE_LO = 3'd2;
  localparam logic [2:0] OFF_RANGE_HI = 3'd3;
  localparam logic [2:0] OFF_LAST     = 3'd5;

  logic [5:0]  pos_q, pos_d;
  logic [2:0]  off_q, off_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [8:0]  base_q, base_d;
  logic        valid_q, valid_d;
  logic [15:0] speed_q, speed_d;
  logic [15:0] int_q, int_d;
  logic [7:0]  rlo_q, rlo_d;

  logic        in_readings;
  logic        sector_ok;
  logic [7:0]  sector_rel;
  logic [5:0]  pos_inc;

  assign in_readings = (pos_q >= ldpd_pkg::FIRST_READING) &&
                       (pos_q <  ldpd_pkg::READINGS_END);
  assign sector_ok   = (byte_i >= ldpd_pkg::SECTOR_LOW) &&
                       (byte_i <= ldpd_pkg::SECTOR_HIGH);
  assign sector_rel  = byte_i - ldpd_pkg::SECTOR_LOW;
  assign pos_inc     = pos_q + 6'd1;

  // Advance the packet position and capture fields
  always_comb begin
    pos_d   = pos_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    valid_d = valid_q;
    speed_d = speed_q;
    int_d   = int_q;
    rlo_d   = rlo_q;
    if (accept_i) begin
      if (pos_q == 6'd0) begin
        if (byte_i == ldpd_pkg::SYNC_BYTE) begin
          pos_d = 6'd1;
        end
      end else begin
        pos_d = (pos_inc == ldpd_pkg::PACKET_BYTES) ? 6'd0 : pos_inc;
        if (pos_q == ldpd_pkg::POS_SECTOR) begin
          valid_d = sector_ok;
          base_d  = sector_ok ? ({1'b0, sector_rel} << 2) + ({1'b0, sector_rel} << 1)
                              : 9'd0;
          cnt_d   = 3'd0;
        end else if (pos_q == ldpd_pkg::POS_SPEED_LO) begin
          speed_d = {speed_q[15:8], byte_i};
        end else if (pos_q == ldpd_pkg::POS_SPEED_HI) begin
          speed_d = {byte_i, speed_q[7:0]};
          off_d   = OFF_INT_LO;
        end else if (in_readings) begin
          off_d = (off_q == OFF_LAST) ? OFF_INT_LO : off_q + 3'd1;
          case (off_q)
            OFF_INT_LO:   int_d = {int_q[15:8], byte_i};
            OFF_INT_HI:   int_d = {byte_i, int_q[7:0]};
            OFF_RANGE_LO: rlo_d = byte_i;
            OFF_RANGE_HI: cnt_d = cnt_q + 3'd1;
            default:      ;
          endcase
        end
      end
    end
  end

  // Emit a reading on its range high byte
  assign rec_valid_o = accept_i && in_readings && (off_q == OFF_RANGE_HI) && valid_q;
  assign rec_o.angle_idx  = base_q + {6'd0, cnt_q};
  assign rec_o.range_mm   = {byte_i, rlo_q};
  assign rec_o.intensity  = int_q;
  assign rec_o.speed_word = speed_q;
  assign rec_o.last       = (cnt_q == ldpd_pkg::LAST_READING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 6'd0;
      off_q   <= 3'd0;
      cnt_q   <= 3'd0;
      base_q  <= 9'd0;
      valid_q <= 1'b0;
      speed_q <= 16'd0;
      int_q   <= 16'd0;
      rlo_q   <= 8'd0;
    end else begin
      pos_q   <= pos_d;
      off_q   <= off_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      valid_q <= valid_d;
      speed_q <= speed_d;
      int_q   <= int_d;
      rlo_q   <= rlo_d;
    end
  end

endmodule

@@ rtl/ldpd_fifo.sv @@
// ---------------------------------------------------------------------------
// ldpd_fifo
// Small queue of reading records between the parser and the output stage.
// ---------------------------------------------------------------------------
module ldpd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  ldpd_pkg::reading_t wr_data_i,
  output logic               full_o,
  input  logic               rd_ready_i,
  output logic               rd_valid_o,
  output ldpd_pkg::reading_t rd_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ldpd_pkg::reading_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  assign full_o     = (count_q == CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  // Store the incoming item
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/ldpd_back.sv @@
// ---------------------------------------------------------------------------
// ldpd_back
// Output stage: folds the angle, scales the motor speed and holds the
// result until it is popped.
// ---------------------------------------------------------------------------
module ldpd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  input  ldpd_pkg::reading_t rec_i,
  output logic               rec_ready_o,
  output logic               empty,
  input  logic               pop,
  output logic [8:0]         angle_deg_o,
  output logic [15:0]        range_mm_o,
  output logic [15:0]        intensity_o,
  output logic [12:0]        motor_rpm_o,
  output logic               last_in_packet_o
);

  logic        valid_q;
  logic        load;
  logic [9:0]  angle_raw;
  logic [9:0]  angle_fold;
  logic [31:0] rpm_prod;

  logic [8:0]  angle_q;
  logic [15:0] range_q, int_q;
  logic [12:0] rpm_q;
  logic        last_q;

  assign rec_ready_o = !valid_q || pop;
  assign load        = rec_valid_i && rec_ready_o;

  // Fold the angle into one turn
  assign angle_raw  = ldpd_pkg::ANGLE_START - {1'b0, rec_i.angle_idx};
  assign angle_fold = (angle_raw >= ldpd_pkg::FULL_TURN) ? angle_raw - ldpd_pkg::FULL_TURN
                                                         : angle_raw;

  // Divide the speed word by ten through the reciprocal
  assign rpm_prod = rec_i.speed_word * ldpd_pkg::RPM_RECIP;

  // Hold the result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      angle_q <= angle_fold[8:0];
      range_q <= rec_i.range_mm;
      int_q   <= rec_i.intensity;
      rpm_q   <= rpm_prod[ldpd_pkg::RPM_SHIFT +: 13];
      last_q  <= rec_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rec_ready_o) begin
      valid_q <= rec_valid_i;
    end
  end

  assign empty            = !valid_q;
  assign angle_deg_o      = angle_q;
  assign range_mm_o       = range_q;
  assign intensity_o      = int_q;
  assign motor_rpm_o      = rpm_q;
  assign last_in_packet_o = last_q;

endmodule

@@ rtl/lidar_packet_deframer.sv @@
// Path: a reading is written into the queue at the edge that accepts its range
//   high byte, then loaded into the output register once the output stage is free.
// Throughput: one byte per cycle while full is low; at most one reading per six
//   bytes, since each reading spans six bytes. full rises only when the queue fills.
// Reset: rst_ni clears packet hunting state, the queue and the output valid flag.
// ---------------------------------------------------------------------------
// lidar_packet_deframer
// Deframes the laser distance sensor byte stream into angle-tagged readings.
// ---------------------------------------------------------------------------
module lidar_packet_deframer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  angle_deg_o,
  output logic [15:0] range_mm_o,
  output logic [15:0] intensity_o,
  output logic [12:0] motor_rpm_o,
  output logic        last_in_packet_o
);

  logic               accept;
  logic               fr_valid;
  ldpd_pkg::reading_t fr_rec;
  logic               q_valid;
  logic               q_ready;
  ldpd_pkg::reading_t q_rec;

  assign accept = push && !full;

  // Parse the byte stream
  ldpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (rx_byte_i),
    .rec_valid_o (fr_valid),
    .rec_o       (fr_rec)
  );

  // Decouple parser from output
  ldpd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_rec),
    .full_o     (full),
    .rd_ready_i (q_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_rec)
  );

  // Compute and hold results
  ldpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (q_valid),
    .rec_i            (q_rec),
    .rec_ready_o      (q_ready),
    .empty            (empty),
    .pop              (pop),
    .angle_deg_o      (angle_deg_o),
    .range_mm_o       (range_mm_o),
    .intensity_o      (intensity_o),
    .motor_rpm_o      (motor_rpm_o),
    .last_in_packet_o (last_in_packet_o)
  );

endmodule

@@ rtl/ldpd_checker.sv @@
// ---------------------------------------------------------------------------
// ldpd_checker
// Port-level checks on the deframer's result stream.
// ---------------------------------------------------------------------------
`include "lidar_packet_deframer_defines.svh"

module ldpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [8:0]  angle_deg_o,
  input logic [15:0] range_mm_o,
  input logic [15:0] intensity_o,
  input logic [12:0] motor_rpm_o,
  input logic        last_in_packet_o
);

  logic [54:0] result_bus;

  // Gather all result fields for the hold check
  assign result_bus = {angle_deg_o, range_mm_o, intensity_o, motor_rpm_o, last_in_packet_o};

  // Hold a waiting item until it is popped
  `LPD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result_bus))

  // Angle stays within one turn
  `LPD_ASSERT(a_angle_range, empty || (angle_deg_o < 9'd360))

  // Speed field divided by ten stays in range
  `LPD_ASSERT(a_rpm_range, empty || (motor_rpm_o <= 13'd6553))

  // With no item waiting anywhere, no byte taken can fill the input side
  `LPD_ASSERT_NEXT(a_full_needs_backlog, full, empty == 1'b0)

endmodule

bind lidar_packet_deframer ldpd_checker u_ldpd_checker (.*);
